// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the core modules.
// Every check is clocked on clk and is ignored while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hcs_pkg.sv
package hcs_pkg;

  // Fixed field widths.
  localparam int VertexW = 4;
  localparam int CountW  = 5;
  localparam int StoreDepth = 16;
  localparam int StepW   = 4;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_EDGE   = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_CYCLE   = 2'd0,
    STATUS_NONE    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // Datapath operations driven by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_PUSH,
    OP_POP,
    OP_LOADCUR,
    OP_EMITRD,
    OP_EMITOUT,
    OP_FINAL,
    OP_NOTFOUND
  } op_t;

  // Jump conditions; COND_NEXT falls through to the following step.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_FULL,
    COND_HIT,
    COND_BOTTOM,
    COND_NOCLOSE,
    COND_NOTLAST
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [StepW-1:0] target;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic full;
    logic hit;
    logic bottom;
    logic noclose;
    logic notlast;
  } flags_t;

  // Program step addresses.
  localparam logic [StepW-1:0] STEP_IDLE     = 4'd0;
  localparam logic [StepW-1:0] STEP_INIT     = 4'd1;
  localparam logic [StepW-1:0] STEP_CHECK    = 4'd2;
  localparam logic [StepW-1:0] STEP_PUSH     = 4'd3;
  localparam logic [StepW-1:0] STEP_POP      = 4'd4;
  localparam logic [StepW-1:0] STEP_RELOAD   = 4'd5;
  localparam logic [StepW-1:0] STEP_CLOSE    = 4'd6;
  localparam logic [StepW-1:0] STEP_EMITRD   = 4'd7;
  localparam logic [StepW-1:0] STEP_EMITOUT  = 4'd8;
  localparam logic [StepW-1:0] STEP_FINAL    = 4'd9;
  localparam logic [StepW-1:0] STEP_NOTFOUND = 4'd10;

  // Search program held in read-only control store.
  function automatic uword_t ucode_rom(logic [StepW-1:0] step);
    uword_t w;
    case (step)
      STEP_INIT:     w = '{OP_INIT,     COND_NEXT,    STEP_IDLE};
      STEP_CHECK:    w = '{OP_NOP,      COND_FULL,    STEP_CLOSE};
      STEP_PUSH:     w = '{OP_PUSH,     COND_HIT,     STEP_CHECK};
      STEP_POP:      w = '{OP_POP,      COND_BOTTOM,  STEP_NOTFOUND};
      STEP_RELOAD:   w = '{OP_LOADCUR,  COND_ALWAYS,  STEP_CHECK};
      STEP_CLOSE:    w = '{OP_NOP,      COND_NOCLOSE, STEP_POP};
      STEP_EMITRD:   w = '{OP_EMITRD,   COND_NEXT,    STEP_IDLE};
      STEP_EMITOUT:  w = '{OP_EMITOUT,  COND_NOTLAST, STEP_EMITRD};
      STEP_FINAL:    w = '{OP_FINAL,    COND_ALWAYS,  STEP_IDLE};
      STEP_NOTFOUND: w = '{OP_NOTFOUND, COND_ALWAYS,  STEP_IDLE};
      default:       w = '{OP_NOP,      COND_ALWAYS,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/hcs_ram.sv
module hcs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/hcs_seq.sv
`include "assert_macros.svh"

module hcs_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start_search,
  input  hcs_pkg::flags_t flags,
  output hcs_pkg::op_t    op,
  output logic            busy
);

  logic [hcs_pkg::StepW-1:0] upc;
  logic [hcs_pkg::StepW-1:0] upc_next;
  hcs_pkg::uword_t           uword;
  logic                      take;

  assign uword = hcs_pkg::ucode_rom(upc);
  assign busy  = (upc != hcs_pkg::STEP_IDLE);
  assign op    = busy ? uword.op : hcs_pkg::OP_NOP;

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (uword.cond)
      hcs_pkg::COND_NEXT:    take = 1'b0;
      hcs_pkg::COND_ALWAYS:  take = 1'b1;
      hcs_pkg::COND_FULL:    take = flags.full;
      hcs_pkg::COND_HIT:     take = flags.hit;
      hcs_pkg::COND_BOTTOM:  take = flags.bottom;
      hcs_pkg::COND_NOCLOSE: take = flags.noclose;
      hcs_pkg::COND_NOTLAST: take = flags.notlast;
      default:               take = 1'b1;
    endcase
  end

  // Next step: launch from idle, otherwise jump or fall through.
  always_comb begin
    if (!busy) begin
      upc_next = start_search ? hcs_pkg::STEP_INIT : hcs_pkg::STEP_IDLE;
    end else if (take) begin
      upc_next = uword.target;
    end else begin
      upc_next = upc + hcs_pkg::StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= hcs_pkg::STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  `ASSERT_NEXT(a_launch, start_search, busy, "search request did not start the sequencer")
  `ASSERT_IMPLIES(a_launch_idle, start_search, !busy, "search launched while busy")

endmodule

// File: rtl/core/hamiltonian_cycle_search_core.sv
// Edge and clear requests are taken back to back while no search runs; an invalid edge gives its
// error result in the cycle after the request. A search holds busy high through its start, each
// candidate scan or closing-edge test, each retreat (pop and stack read), then a stack read and
// an output per emitted vertex and the closing result; the walk sets the total.
// Results are one-cycle strobes; the receiver cannot stall them.
// Synchronous reset clears the graph and the search state and sets vertex_count to 16.
`include "assert_macros.svh"

module hamiltonian_cycle_search_core #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [hcs_pkg::VertexW-1:0] edge_from,
  input  logic [hcs_pkg::VertexW-1:0] edge_to,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hcs_pkg::CountW-1:0]  cfg_data,
  output logic                        result_valid,
  output logic [1:0]                  status,
  output logic [hcs_pkg::CountW-1:0]  position,
  output logic [hcs_pkg::VertexW-1:0] vertex,
  output logic                        last
);

  localparam int CountW  = hcs_pkg::CountW;
  localparam int VertexW = hcs_pkg::VertexW;
  localparam int NumV    = (MAX_VERTICES < hcs_pkg::StoreDepth) ? MAX_VERTICES
                                                                 : hcs_pkg::StoreDepth;
  localparam int VIdxW   = $clog2(NumV);
  localparam logic [CountW-1:0] NumVC = CountW'(NumV);

  logic [CountW-1:0]  vertex_count;
  logic [CountW-1:0]  nv;
  logic [CountW-1:0]  nv_m1;
  logic [NumV-1:0]    adjacency [NumV];
  logic [NumV-1:0]    visited;
  logic [CountW-1:0]  depth;
  logic [CountW-1:0]  depth_m2;
  logic [CountW-1:0]  cand;
  logic [CountW-1:0]  idx;
  logic [VertexW-1:0] cur;
  logic [VIdxW-1:0]   cur_idx;
  logic [NumV-1:0]    row;
  logic [NumV-1:0]    cand_bits;
  logic               hit;
  logic [VertexW-1:0] hit_v;
  logic [VIdxW-1:0]   hit_idx;
  logic               accept;
  logic               start_search;
  logic               edge_ok;
  hcs_pkg::op_t       op;
  hcs_pkg::flags_t    flags;
  logic               ram_we;
  logic [VIdxW-1:0]   ram_waddr;
  logic [VertexW-1:0] ram_wdata;
  logic [VIdxW-1:0]   ram_raddr;
  logic [VertexW-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign accept       = start && !busy;
  assign start_search = accept && (req_type == hcs_pkg::REQ_SEARCH);

  // Active vertex count: zero acts as one, large values clamp to NumV (MAX_VERTICES or the store depth, if smaller).
  always_comb begin
    if (vertex_count == '0) begin
      nv = CountW'(1);
    end else if (vertex_count > NumVC) begin
      nv = NumVC;
    end else begin
      nv = vertex_count;
    end
  end
  assign nv_m1    = nv - CountW'(1);
  assign depth_m2 = depth - CountW'(2);

  assign edge_ok = (CountW'(edge_from) < nv) && (CountW'(edge_to) < nv)
                   && (edge_from != edge_to);

  // Candidate scan: lowest unvisited neighbor at or above cand and below nv.
  assign cur_idx = cur[VIdxW-1:0];
  assign row     = adjacency[cur_idx];
  always_comb begin
    for (int v = 0; v < NumV; v++) begin
      cand_bits[v] = row[v] && !visited[v] && (CountW'(v) >= cand) && (CountW'(v) < nv);
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_v = '0;
    for (int v = NumV - 1; v >= 0; v--) begin
      if (cand_bits[v]) begin
        hit   = 1'b1;
        hit_v = VertexW'(v);
      end
    end
  end
  assign hit_idx = hit_v[VIdxW-1:0];

  // Flags for the sequencer's conditional jumps.
  assign flags.full    = (depth >= nv);
  assign flags.hit     = hit;
  assign flags.bottom  = (depth <= CountW'(1));
  assign flags.noclose = !row[0];
  assign flags.notlast = (idx != nv_m1);

  hcs_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start_search (start_search),
    .flags        (flags),
    .op           (op),
    .busy         (busy)
  );

  // Path stack port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = idx[VIdxW-1:0];
    case (op)
      hcs_pkg::OP_INIT: begin
        ram_we = 1'b1;
      end
      hcs_pkg::OP_PUSH: begin
        ram_we    = hit;
        ram_waddr = depth[VIdxW-1:0];
        ram_wdata = hit_v;
      end
      hcs_pkg::OP_POP: begin
        ram_raddr = depth_m2[VIdxW-1:0];
      end
      default: begin
        ram_raddr = idx[VIdxW-1:0];
      end
    endcase
  end

  hcs_ram #(
    .WIDTH (VertexW),
    .DEPTH (NumV)
  ) u_path_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration, graph store, search registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CountW'(16);
      for (int r = 0; r < NumV; r++) begin
        adjacency[r] <= '0;
      end
      visited      <= '0;
      depth        <= '0;
      cand         <= '0;
      idx          <= '0;
      cur          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end

      // Requests taken while idle.
      if (accept && (req_type == hcs_pkg::REQ_EDGE)) begin
        if (edge_ok) begin
          adjacency[edge_from[VIdxW-1:0]][edge_to[VIdxW-1:0]] <= 1'b1;
          adjacency[edge_to[VIdxW-1:0]][edge_from[VIdxW-1:0]] <= 1'b1;
        end else begin
          result_valid <= 1'b1;
          status       <= hcs_pkg::STATUS_INVALID;
          position     <= '0;
          vertex       <= '0;
          last         <= 1'b1;
        end
      end
      if (accept && (req_type == hcs_pkg::REQ_CLEAR)) begin
        for (int r = 0; r < NumV; r++) begin
          adjacency[r] <= '0;
        end
      end

      // Datapath operation chosen by the current control word.
      case (op)
        hcs_pkg::OP_INIT: begin
          visited <= NumV'(1);
          depth   <= CountW'(1);
          cand    <= CountW'(1);
          cur     <= '0;
          idx     <= '0;
        end
        hcs_pkg::OP_PUSH: begin
          if (hit) begin
            visited[hit_idx] <= 1'b1;
            depth            <= depth + CountW'(1);
            cand             <= CountW'(1);
            cur              <= hit_v;
          end
        end
        hcs_pkg::OP_POP: begin
          if (!flags.bottom) begin
            visited[cur_idx] <= 1'b0;
            cand             <= CountW'(cur) + CountW'(1);
            depth            <= depth - CountW'(1);
          end
        end
        hcs_pkg::OP_LOADCUR: begin
          cur <= ram_rdata;
        end
        hcs_pkg::OP_EMITOUT: begin
          result_valid <= 1'b1;
          status       <= hcs_pkg::STATUS_CYCLE;
          position     <= idx;
          vertex       <= ram_rdata;
          last         <= 1'b0;
          idx          <= idx + CountW'(1);
        end
        hcs_pkg::OP_FINAL: begin
          result_valid <= 1'b1;
          status       <= hcs_pkg::STATUS_CYCLE;
          position     <= nv;
          vertex       <= '0;
          last         <= 1'b1;
        end
        hcs_pkg::OP_NOTFOUND: begin
          result_valid <= 1'b1;
          status       <= hcs_pkg::STATUS_NONE;
          position     <= '0;
          vertex       <= '0;
          last         <= 1'b1;
        end
        default: begin
          cand <= cand;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_depth_bound, busy && (op != hcs_pkg::OP_INIT), depth <= nv, "path depth beyond vertex count")
  `ASSERT_IMPLIES(a_root_visited, busy && (op != hcs_pkg::OP_INIT), visited[0], "start vertex dropped from visited mask")
  `ASSERT_IMPLIES(a_cycle_pos, result_valid && (status == hcs_pkg::STATUS_CYCLE) && !last, position < nv, "cycle vertex position out of range")

endmodule
